@@ design/boundary_tag_best_fit_allocator_unit_macros.svh @@
// Assertion macros for the boundary tag best fit allocator.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef BOUNDARY_TAG_BEST_FIT_ALLOCATOR_UNIT_MACROS_SVH
`define BOUNDARY_TAG_BEST_FIT_ALLOCATOR_UNIT_MACROS_SVH
`define BTBFA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BTBFA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`endif

@@ design/btbfa_pkg.sv @@
// Shared types and constants for the boundary tag best fit allocator.
// No dependencies.
package btbfa_pkg;

  localparam int unsigned PoolDepth = 4096;
  localparam int unsigned AddrW     = $clog2(PoolDepth);
  localparam logic [12:0] CfgReset  = 13'd4096;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_DFREE = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [11:0] request_size;
    logic [11:0] block_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] payload_address;
  } rsp_t;

  typedef enum logic [3:0] {
    BS_ZERO, BS_POS, BS_BEST, BS_BREQ, BS_BORIG, BS_H, BS_HSZ, BS_HSZNX, BS_HPV, BS_P
  } base_e;

  typedef enum logic [2:0] {
    VAL_ZERO, VAL_ONE, VAL_LEFT, VAL_REQ, VAL_INIT, VAL_M1, VAL_M2, VAL_M3
  } val_e;

  typedef enum logic [3:0] {
    LD_NONE, LD_START, LD_FLAG, LD_LO, LD_SCAN, LD_SZ, LD_NX, LD_PV, LD_MNX
  } ld_e;

  typedef struct packed {
    logic              we;
    base_e             base;
    logic signed [4:0] off;
    val_e              val;
    logic              hi;
    ld_e               ld;
    logic              res_ld;
    status_e           res_st;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       rd_zero;
    logic       more;
    logic       found;
    logic       split;
    logic       nx_ok;
    logic       h_zero;
    logic       merged;
    logic       out_busy;
  } stat_t;

  typedef enum logic [5:0] {
    S_IDLE, S_DISP, S_RES_OK, S_RES_NOFIT, S_RES_DFREE,
    S_A0, S_A1, S_A2, S_A3, S_A4,
    S_AW0, S_AW1, S_AW2, S_AW3, S_AW4, S_AW5, S_AW6, S_AW7, S_AW8, S_AFL,
    S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_F7, S_F8, S_F9, S_F10, S_F11,
    S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8,
    S_I0, S_I1, S_I2, S_I3, S_I4
  } state_e;

endpackage

@@ design/btbfa_dp.sv @@
// Datapath of the allocator: pool memory, walk registers, address and data muxes.
// Depends on btbfa_pkg; driven by btbfa_ctrl commands.
module btbfa_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [12:0]      cfg_data_i,
  input  btbfa_pkg::req_t  in_req_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output btbfa_pkg::rsp_t  out_rsp_o,
  input  btbfa_pkg::cmd_t  cmd_i,
  output btbfa_pkg::stat_t stat_o
);
  import btbfa_pkg::*;

  logic [7:0]       mem [PoolDepth];
  logic [7:0]       rdata_q;
  logic [12:0]      cfg_q;
  logic [1:0]       op_q;
  logic [11:0]      req_q, h_q, best_q;
  logic [16:0]      pos_q;
  logic             found_q, mnx_q, flag_zero_q, out_valid_q;
  logic [15:0]      bsize_q, sz_q, nx_q, pv_q;
  logic [7:0]       lo_q;
  rsp_t             out_q;
  logic [12:0]      p;
  logic [AddrW-1:0] base, addr;
  logic [15:0]      val, rd16;
  logic [7:0]       wdata;
  logic [16:0]      req5;
  logic [16:0]      three_req5;

  always_comb begin
    if (cfg_q < 13'd16) p = 13'd16;
    else if (cfg_q > 13'(PoolDepth)) p = 13'(PoolDepth);
    else p = cfg_q;
  end

  assign rd16       = {rdata_q, lo_q};
  assign req5       = 17'(req_q) + 17'd5;
  assign three_req5 = {req5[15:0], 1'b0} + req5;

  always_comb begin
    case (cmd_i.base)
      BS_ZERO:  base = '0;
      BS_POS:   base = pos_q[AddrW-1:0];
      BS_BEST:  base = best_q;
      BS_BREQ:  base = best_q + req_q;
      BS_BORIG: base = best_q + bsize_q[AddrW-1:0];
      BS_H:     base = h_q;
      BS_HSZ:   base = h_q + sz_q[AddrW-1:0];
      BS_HSZNX: base = h_q + sz_q[AddrW-1:0] + nx_q[AddrW-1:0];
      BS_HPV:   base = h_q - pv_q[AddrW-1:0];
      BS_P:     base = p[AddrW-1:0];
      default:  base = '0;
    endcase
  end

  assign addr = base + {{(AddrW-5){cmd_i.off[4]}}, cmd_i.off};

  always_comb begin
    case (cmd_i.val)
      VAL_ZERO: val = 16'd0;
      VAL_ONE:  val = 16'd1;
      VAL_LEFT: val = bsize_q - 16'(req_q) - 16'd5;
      VAL_REQ:  val = 16'(req_q);
      VAL_INIT: val = 16'(p) - 16'd5;
      VAL_M1:   val = sz_q + nx_q + 16'd5;
      VAL_M2:   val = sz_q + nx_q + pv_q + 16'd10;
      VAL_M3:   val = sz_q + pv_q + 16'd5;
      default:  val = 16'd0;
    endcase
  end

  assign wdata = cmd_i.hi ? val[15:8] : val[7:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem[addr] <= wdata;
    end
    rdata_q <= mem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q    <= '0;
      pos_q   <= '0;
      found_q <= 1'b0;
      mnx_q   <= 1'b0;
    end else begin
      case (cmd_i.ld)
        LD_START: begin
          op_q    <= in_req_i.opcode;
          pos_q   <= '0;
          found_q <= 1'b0;
          mnx_q   <= 1'b0;
        end
        LD_SCAN: begin
          if (flag_zero_q && req5 < 17'(rd16) && rd16 < bsize_q) begin
            found_q <= 1'b1;
          end
          pos_q <= pos_q + 17'(rd16) + 17'd5;
        end
        LD_MNX: begin
          mnx_q <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.ld)
      LD_START: begin
        req_q   <= in_req_i.request_size;
        h_q     <= in_req_i.block_address - 12'd3;
        bsize_q <= 16'(p);
      end
      LD_FLAG: flag_zero_q <= (rdata_q == 8'd0);
      LD_LO:   lo_q <= rdata_q;
      LD_SCAN: begin
        if (flag_zero_q && req5 < 17'(rd16) && rd16 < bsize_q) begin
          best_q  <= pos_q[AddrW-1:0];
          bsize_q <= rd16;
        end
      end
      LD_SZ:   sz_q <= rd16;
      LD_NX:   nx_q <= rd16;
      LD_PV:   pv_q <= rd16;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_ld) begin
      out_q.status <= cmd_i.res_st;
      out_q.payload_address <= (cmd_i.res_st == ST_OK && op_q == OP_ALLOC)
                               ? best_q + 12'd3 : 12'd0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_rsp_o       = out_q;
  assign stat_o.op       = op_q;
  assign stat_o.rd_zero  = (rdata_q == 8'd0);
  assign stat_o.more     = pos_q < 17'(p);
  assign stat_o.found    = found_q;
  assign stat_o.split    = {bsize_q, 1'b0} > three_req5;
  assign stat_o.nx_ok    = 17'(h_q) + 17'(sz_q) + 17'd5 < 17'(p);
  assign stat_o.h_zero   = (h_q == '0);
  assign stat_o.merged   = mnx_q;
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

endmodule

@@ design/btbfa_ctrl.sv @@
// Sequencer of the allocator: walks blocks and issues memory commands.
// Depends on btbfa_pkg; drives btbfa_dp.
module btbfa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  btbfa_pkg::stat_t stat_i,
  output btbfa_pkg::cmd_t  cmd_o
);
  import btbfa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_DISP;
      S_DISP: begin
        case (stat_i.op)
          OP_ALLOC: state_d = S_A0;
          OP_FREE:  state_d = S_F0;
          OP_INIT:  state_d = S_I0;
          default:  state_d = S_RES_OK;
        endcase
      end
      S_RES_OK, S_RES_NOFIT, S_RES_DFREE: if (!stat_i.out_busy) state_d = S_IDLE;
      S_A0: state_d = stat_i.more ? S_A1 : S_A4;
      S_A1: state_d = S_A2;
      S_A2: state_d = S_A3;
      S_A3: state_d = S_A0;
      S_A4: begin
        if (!stat_i.found) state_d = S_RES_NOFIT;
        else if (stat_i.split) state_d = S_AW0;
        else state_d = S_AFL;
      end
      S_AW0: state_d = S_AW1;
      S_AW1: state_d = S_AW2;
      S_AW2: state_d = S_AW3;
      S_AW3: state_d = S_AW4;
      S_AW4: state_d = S_AW5;
      S_AW5: state_d = S_AW6;
      S_AW6: state_d = S_AW7;
      S_AW7: state_d = S_AW8;
      S_AW8: state_d = S_AFL;
      S_AFL: state_d = S_RES_OK;
      S_F0:  state_d = S_F1;
      S_F1:  state_d = stat_i.rd_zero ? S_RES_DFREE : S_F2;
      S_F2:  state_d = S_F3;
      S_F3:  state_d = S_F4;
      S_F4:  state_d = stat_i.nx_ok ? S_F5 : S_P0;
      S_F5:  state_d = stat_i.rd_zero ? S_F6 : S_P0;
      S_F6:  state_d = S_F7;
      S_F7:  state_d = S_F8;
      S_F8:  state_d = S_F9;
      S_F9:  state_d = S_F10;
      S_F10: state_d = S_F11;
      S_F11: state_d = S_P0;
      S_P0:  state_d = stat_i.h_zero ? S_RES_OK : S_P1;
      S_P1:  state_d = S_P2;
      S_P2:  state_d = S_P3;
      S_P3:  state_d = S_P4;
      S_P4:  state_d = stat_i.rd_zero ? S_P5 : S_RES_OK;
      S_P5:  state_d = S_P6;
      S_P6:  state_d = S_P7;
      S_P7:  state_d = S_P8;
      S_P8:  state_d = S_RES_OK;
      S_I0:  state_d = S_I1;
      S_I1:  state_d = S_I2;
      S_I2:  state_d = S_I3;
      S_I3:  state_d = S_I4;
      S_I4:  state_d = S_RES_OK;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.base   = BS_ZERO;
    cmd_o.val    = VAL_ZERO;
    cmd_o.ld     = LD_NONE;
    cmd_o.res_st = ST_OK;
    in_ready_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.ld = LD_START;
      end
      S_RES_OK:    cmd_o.res_ld = !stat_i.out_busy;
      S_RES_NOFIT: begin
        cmd_o.res_ld = !stat_i.out_busy;
        cmd_o.res_st = ST_NOFIT;
      end
      S_RES_DFREE: begin
        cmd_o.res_ld = !stat_i.out_busy;
        cmd_o.res_st = ST_DFREE;
      end
      S_A0: cmd_o.base = BS_POS;
      S_A1: begin
        cmd_o.ld = LD_FLAG; cmd_o.base = BS_POS; cmd_o.off = 5'sd1;
      end
      S_A2: begin
        cmd_o.ld = LD_LO; cmd_o.base = BS_POS; cmd_o.off = 5'sd2;
      end
      S_A3: cmd_o.ld = LD_SCAN;
      S_AW0: begin
        cmd_o.we = 1'b1; cmd_o.base = BS_BREQ; cmd_o.off = 5'sd5;
      end
      S_AW1: begin
        cmd_o.we = 1'b1; cmd_o.base = BS_BREQ; cmd_o.off = 5'sd6; cmd_o.val = VAL_LEFT;
      end
      S_AW2: begin
        cmd_o.we = 1'b1; cmd_o.base = BS_BREQ; cmd_o.off = 5'sd7; cmd_o.val = VAL_LEFT;
        cmd_o.hi = 1'b1;
      end
      S_AW3: begin
        cmd_o.we = 1'b1; cmd_o.base = BS_BORIG; cmd_o.off = 5'sd3; cmd_o.val = VAL_LEFT;
      end
      S_AW4: begin
        cmd_o.we = 1'b1; cmd_o.base = BS_BORIG; cmd_o.off = 5'sd4; cmd_o.val = VAL_LEFT;
        cmd_o.hi = 1'b1;
      end
      S_AW5: begin
        cmd_o.we = 1'b1; cmd_o.base = BS_BREQ; cmd_o.off = 5'sd3; cmd_o.val = VAL_REQ;
      end
      S_AW6: begin
        cmd_o.we = 1'b1; cmd_o.base = BS_BREQ; cmd_o.off = 5'sd4; cmd_o.val = VAL_REQ;
        cmd_o.hi = 1'b1;
      end
      S_AW7: begin
        cmd_o.we = 1'b1; cmd_o.base = BS_BEST; cmd_o.off = 5'sd1; cmd_o.val = VAL_REQ;
      end
      S_AW8: begin
        cmd_o.we = 1'b1; cmd_o.base = BS_BEST; cmd_o.off = 5'sd2; cmd_o.val = VAL_REQ;
        cmd_o.hi = 1'b1;
      end
      S_AFL: begin
        cmd_o.we = 1'b1; cmd_o.base = BS_BEST; cmd_o.val = VAL_ONE;
      end
      S_F0: cmd_o.base = BS_H;
      S_F1: begin
        cmd_o.base = BS_H; cmd_o.off = 5'sd1;
      end
      S_F2: begin
        cmd_o.ld = LD_LO; cmd_o.base = BS_H; cmd_o.off = 5'sd2;
      end
      S_F3: begin
        cmd_o.ld = LD_SZ; cmd_o.we = 1'b1; cmd_o.base = BS_H;
      end
      S_F4: begin
        cmd_o.base = BS_HSZ; cmd_o.off = 5'sd5;
      end
      S_F5: begin
        cmd_o.base = BS_HSZ; cmd_o.off = 5'sd6;
      end
      S_F6: begin
        cmd_o.ld = LD_LO; cmd_o.base = BS_HSZ; cmd_o.off = 5'sd7;
      end
      S_F7: cmd_o.ld = LD_NX;
      S_F8: begin
        cmd_o.we = 1'b1; cmd_o.base = BS_H; cmd_o.off = 5'sd1; cmd_o.val = VAL_M1;
      end
      S_F9: begin
        cmd_o.we = 1'b1; cmd_o.base = BS_H; cmd_o.off = 5'sd2; cmd_o.val = VAL_M1;
        cmd_o.hi = 1'b1;
      end
      S_F10: begin
        cmd_o.we = 1'b1; cmd_o.base = BS_HSZNX; cmd_o.off = 5'sd8; cmd_o.val = VAL_M1;
      end
      S_F11: begin
        cmd_o.we = 1'b1; cmd_o.base = BS_HSZNX; cmd_o.off = 5'sd9; cmd_o.val = VAL_M1;
        cmd_o.hi = 1'b1; cmd_o.ld = LD_MNX;
      end
      S_P0: begin
        cmd_o.base = BS_H; cmd_o.off = -5'sd2;
      end
      S_P1: begin
        cmd_o.ld = LD_LO; cmd_o.base = BS_H; cmd_o.off = -5'sd1;
      end
      S_P2: cmd_o.ld = LD_PV;
      S_P3: begin
        cmd_o.base = BS_HPV; cmd_o.off = -5'sd5;
      end
      S_P5: begin
        cmd_o.we = 1'b1; cmd_o.base = BS_HPV; cmd_o.off = -5'sd4;
        cmd_o.val = stat_i.merged ? VAL_M2 : VAL_M3;
      end
      S_P6: begin
        cmd_o.we = 1'b1; cmd_o.base = BS_HPV; cmd_o.off = -5'sd3;
        cmd_o.val = stat_i.merged ? VAL_M2 : VAL_M3; cmd_o.hi = 1'b1;
      end
      S_P7: begin
        cmd_o.we   = 1'b1;
        cmd_o.base = stat_i.merged ? BS_HSZNX : BS_HSZ;
        cmd_o.off  = stat_i.merged ? 5'sd8 : 5'sd3;
        cmd_o.val  = stat_i.merged ? VAL_M2 : VAL_M3;
      end
      S_P8: begin
        cmd_o.we   = 1'b1;
        cmd_o.base = stat_i.merged ? BS_HSZNX : BS_HSZ;
        cmd_o.off  = stat_i.merged ? 5'sd9 : 5'sd4;
        cmd_o.val  = stat_i.merged ? VAL_M2 : VAL_M3;
        cmd_o.hi   = 1'b1;
      end
      S_I0: begin
        cmd_o.we = 1'b1;
      end
      S_I1: begin
        cmd_o.we = 1'b1; cmd_o.off = 5'sd1; cmd_o.val = VAL_INIT;
      end
      S_I2: begin
        cmd_o.we = 1'b1; cmd_o.off = 5'sd2; cmd_o.val = VAL_INIT; cmd_o.hi = 1'b1;
      end
      S_I3: begin
        cmd_o.we = 1'b1; cmd_o.base = BS_P; cmd_o.off = -5'sd2; cmd_o.val = VAL_INIT;
      end
      S_I4: begin
        cmd_o.we = 1'b1; cmd_o.base = BS_P; cmd_o.off = -5'sd1; cmd_o.val = VAL_INIT;
        cmd_o.hi = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ design/boundary_tag_best_fit_allocator_unit.sv @@
// One request at a time; the walk reads one pool byte per cycle through the
// single memory port, so block count sets allocate latency.
// A finished response waits in an output register while the next request enters.
// Reset (async, active low) idles the sequencer and sets pool size to 4096;
// pool contents are undefined until an init request.
// Top level; depends on btbfa_pkg, btbfa_ctrl, btbfa_dp and the macros header.
module boundary_tag_best_fit_allocator_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  btbfa_pkg::req_t in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output btbfa_pkg::rsp_t out_rsp_o,
  input  logic            cfg_we_i,
  input  logic [12:0]     cfg_data_i
);
  import btbfa_pkg::*;
  `include "boundary_tag_best_fit_allocator_unit_macros.svh"

  cmd_t  cmd;
  stat_t stat;

  btbfa_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  btbfa_dp u_dp (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_data_i,
    .in_req_i,
    .out_ready_i,
    .out_valid_o,
    .out_rsp_o,
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  `BTBFA_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready after accept")
  `BTBFA_ASSERT(a_addr_zero_on_fail, out_valid_o && out_rsp_o.status != ST_OK |-> out_rsp_o.payload_address == '0, "address on failure")
  `BTBFA_ASSERT(a_status_legal, out_valid_o |-> (out_rsp_o.status == ST_OK || out_rsp_o.status == ST_NOFIT || out_rsp_o.status == ST_DFREE), "bad status")

endmodule

@@ verif/tb.sv @@
// Testbench for boundary_tag_best_fit_allocator_unit: directed and random
// allocate/free/init requests are checked against an in-bench pool predictor.
// Depends on btbfa_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb;
  import btbfa_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int HeadB = 3;
  localparam int FootB = 2;
  localparam int TagB  = 5;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  req_t        in_req_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  rsp_t        out_rsp_o;
  logic        cfg_we_i = 1'b0;
  logic [12:0] cfg_data_i = '0;

  boundary_tag_best_fit_allocator_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_req_i,
    .out_valid_o, .out_ready_i, .out_rsp_o, .cfg_we_i, .cfg_data_i
  );

  always #4 clk_i = ~clk_i;

  logic [7:0]  pool_mem [PoolDepth];
  bit          pool_wr [PoolDepth];
  logic [7:0]  save_mem [PoolDepth];
  bit          save_wr [PoolDepth];
  logic [12:0] pool_cfg = CfgReset;
  bit          hit_unwritten;

  rsp_t rsp_q[$];
  int   live_q[$];
  int   freed_q[$];
  int   err_cnt = 0;
  int   snd_idle_pct = 0;
  int   rcv_stall_pct = 0;

  initial foreach (pool_mem[i]) begin
    pool_mem[i] = 8'h00;
    pool_wr[i] = 1'b0;
  end

  function automatic int wrap_a(int a);
    int r;
    r = a % PoolDepth;
    if (r < 0) r += PoolDepth;
    return r;
  endfunction

  function automatic int rd8(int a);
    if (!pool_wr[wrap_a(a)]) hit_unwritten = 1'b1;
    return int'(pool_mem[wrap_a(a)]);
  endfunction

  function automatic int rd16(int a);
    return rd8(a) | (rd8(a + 1) << 8);
  endfunction

  function automatic void wr8(int a, int v);
    pool_mem[wrap_a(a)] = v[7:0];
    pool_wr[wrap_a(a)] = 1'b1;
  endfunction

  function automatic void wr16(int a, int v);
    wr8(a, v & 'hFF);
    wr8(a + 1, (v >> 8) & 'hFF);
  endfunction

  function automatic int pool_span();
    int p;
    p = int'(pool_cfg);
    if (p < 16) p = 16;
    if (p > PoolDepth) p = PoolDepth;
    return p;
  endfunction

  function automatic void fmt_pool();
    int p;
    p = pool_span();
    wr8(0, 0);
    wr16(1, (p - TagB) & 'hFFFF);
    wr16(p - FootB, (p - TagB) & 'hFFFF);
  endfunction

  function automatic status_e alloc_blk(int req, output int addr);
    int p, pos, best, best_sz, sz, orig, left;
    p = pool_span();
    pos = 0;
    best = -1;
    best_sz = p;
    addr = 0;
    while (pos < p) begin
      sz = rd16(pos + 1);
      if (rd8(pos) == 0 && req + TagB < sz && sz < best_sz) begin
        best = pos;
        best_sz = sz;
      end
      pos += sz + TagB;
    end
    if (best < 0) return ST_NOFIT;
    orig = rd16(best + 1);
    if (orig * 2 > 3 * (req + TagB)) begin
      left = (orig - req - TagB) & 'hFFFF;
      wr8(best + req + TagB, 0);
      wr16(best + req + TagB + 1, left);
      wr16(best + orig + HeadB, left);
      wr16(best + req + HeadB, req);
      wr16(best + 1, req);
    end
    wr8(best, 1);
    addr = wrap_a(best + HeadB) & 'hFFF;
    return ST_OK;
  endfunction

  function automatic status_e free_blk(int baddr);
    int p, h, o, sz, nx, pv, msz;
    bit mnx;
    p = pool_span();
    h = wrap_a(baddr - HeadB);
    o = h + HeadB;
    nx = 0;
    mnx = 1'b0;
    if (rd8(h) == 0) return ST_DFREE;
    sz = rd16(h + 1);
    wr8(h, 0);
    if (o + sz + FootB < p && rd8(o + sz + FootB) == 0) begin
      nx = rd16(o + sz + HeadB);
      msz = (sz + nx + TagB) & 'hFFFF;
      wr16(o - FootB, msz);
      wr16(o + sz + TagB + nx, msz);
      mnx = 1'b1;
    end
    if (h > 0) begin
      pv = rd16(o - TagB);
      if (rd8(o - TagB - HeadB - pv) == 0) begin
        if (mnx) begin
          msz = (sz + nx + pv + 2 * TagB) & 'hFFFF;
          wr16(o - TagB - FootB - pv, msz);
          wr16(o + sz + TagB + nx, msz);
        end else begin
          msz = (sz + pv + TagB) & 'hFFFF;
          wr16(o - TagB - FootB - pv, msz);
          wr16(o + sz, msz);
        end
      end
    end
    return ST_OK;
  endfunction

  function automatic rsp_t pool_step(req_t r);
    rsp_t e;
    int   a;
    e = '0;
    case (r.opcode)
      OP_ALLOC: begin
        e.status = alloc_blk(int'(r.request_size), a);
        e.payload_address = (e.status == ST_OK) ? a[11:0] : 12'd0;
      end
      OP_FREE: e.status = free_blk(int'(r.block_address));
      OP_INIT: fmt_pool();
      default: ;
    endcase
    return e;
  endfunction

  function automatic bit reads_written_only(req_t r);
    save_mem = pool_mem;
    save_wr = pool_wr;
    hit_unwritten = 1'b0;
    void'(pool_step(r));
    pool_mem = save_mem;
    pool_wr = save_wr;
    return !hit_unwritten;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rcv_stall_pct);
  end

  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rsp_q.size() == 0) begin
        report("unexpected response", int'(out_rsp_o.status), -1);
      end else begin
        e = rsp_q.pop_front();
        if (out_rsp_o.status !== e.status)
          report("status", int'(out_rsp_o.status), int'(e.status));
        if (out_rsp_o.payload_address !== e.payload_address)
          report("payload_address", int'(out_rsp_o.payload_address),
                 int'(e.payload_address));
      end
    end
  end

  task automatic send(req_t r);
    rsp_t e;
    int   idx[$];
    if (!reads_written_only(r)) r.opcode = OP_INIT;
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    e = pool_step(r);
    rsp_q.push_back(e);
    if (r.opcode == OP_INIT) live_q.delete();
    if (r.opcode == OP_ALLOC && e.status == ST_OK) live_q.push_back(int'(e.payload_address));
    if (r.opcode == OP_FREE && e.status == ST_OK) begin
      idx = live_q.find_first_index(x) with (x == int'(r.block_address));
      if (idx.size() > 0) live_q.delete(idx[0]);
      freed_q.push_back(int'(r.block_address));
      if (freed_q.size() > 32) void'(freed_q.pop_front());
    end
  endtask

  task automatic send_op(logic [1:0] op, int sz, int addr);
    req_t r;
    r.opcode = op;
    r.request_size = sz[11:0];
    r.block_address = addr[11:0];
    send(r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (rsp_q.size() > 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_pool_size(logic [12:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pool_cfg = v;
  endtask

  function automatic int live_pick();
    return live_q.size() ? live_q[$urandom_range(live_q.size() - 1)] : $urandom_range(4095);
  endfunction

  task automatic test_directed();
    int a0, a1, a2;
    send_op(OP_INIT, 0, 0);
    send_op(OP_ALLOC, 0, 0);
    send_op(OP_ALLOC, 4095, 0);
    send_op(OP_ALLOC, 4091, 0);
    send_op(OP_ALLOC, 100, 0);
    send_op(OP_ALLOC, 200, 0);
    send_op(OP_ALLOC, 50, 0);
    a0 = 3;
    a1 = 3 + 5;
    a2 = a1 + 105;
    send_op(OP_FREE, 0, a1);
    send_op(OP_FREE, 0, a1);
    send_op(OP_FREE, 0, a0);
    send_op(OP_FREE, 0, a2);
    send_op(OP_NONE, 4095, 4095);
    send_op(OP_ALLOC, 3000, 0);
    send_op(OP_ALLOC, 3900, 0);
    send_op(OP_FREE, 0, 4095);
    send_op(OP_FREE, 0, 0);
    send_op(OP_FREE, 0, live_pick());
    send_op(OP_INIT, 0, 0);
    send_op(OP_ALLOC, 4084, 0);
    send_op(OP_ALLOC, 2725, 0);
    send_op(OP_FREE, 0, live_pick());
  endtask

  task automatic test_pool_sizes();
    logic [12:0] sizes[9] = '{13'd0, 13'd15, 13'd16, 13'd17, 13'd100,
                              13'd4097, 13'd8191, 13'd300, CfgReset};
    foreach (sizes[i]) begin
      write_pool_size(sizes[i]);
      send_op(OP_ALLOC, 2, 0);
      send_op(OP_INIT, 0, 0);
      send_op(OP_ALLOC, 0, 0);
      send_op(OP_ALLOC, 5, 0);
      send_op(OP_ALLOC, 20, 0);
      send_op(OP_FREE, 0, live_pick());
      send_op(OP_ALLOC, 4095, 0);
      send_op(OP_FREE, 0, live_pick());
    end
  endtask

  task automatic test_random();
    int idle[4][2] = '{'{0, 0}, '{58, 0}, '{0, 58}, '{22, 22}};
    int span[4] = '{256, 1200, 512, 800};
    int k, sz;
    for (int ph = 0; ph < 4; ph++) begin
      write_pool_size(13'(span[ph]));
      snd_idle_pct = idle[ph][0];
      rcv_stall_pct = idle[ph][1];
      send_op(OP_INIT, 0, 0);
      repeat (420) begin
        k = $urandom_range(99);
        sz = $urandom_range(99);
        sz = (sz < 80) ? $urandom_range(40) : (sz < 95) ? $urandom_range(300)
                                                           : $urandom_range(4095);
        if (k < 48) send_op(OP_ALLOC, sz, $urandom_range(4095));
        else if (k < 86) send_op(OP_FREE, $urandom_range(4095), live_pick());
        else if (k < 92 && freed_q.size() > 0)
          send_op(OP_FREE, 0, freed_q[$urandom_range(freed_q.size() - 1)]);
        else if (k < 95) send_op(OP_FREE, 0, $urandom_range(4095));
        else if (k < 98) send_op(OP_INIT, sz, $urandom_range(4095));
        else send_op(OP_NONE, sz, $urandom_range(4095));
      end
    end
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_pool_sizes();
    test_random();
    drain();
    if (err_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
